>>> sv/assert_macros.svh
// Assertion macros shared by the header parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> sv/pnm_pkg.sv
// Types and constants shared by the header parser modules.
package pnm_pkg;

    // Parse phases of the byte-level header scanner
    typedef enum logic [2:0] {
        PH_SEEK_P,
        PH_TYPE,
        PH_SEEK_W,
        PH_WIDTH,
        PH_SEEK_H,
        PH_HEIGHT,
        PH_DONE
    } t_phase;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_TRUNC   = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_X_MIN = 3'd0,
        REG_X_MAX = 3'd1,
        REG_Y_MIN = 3'd2,
        REG_Y_MAX = 3'd3,
        REG_Z_MIN = 3'd4,
        REG_Z_MAX = 3'd5
    } t_reg_idx;

    localparam int REG_W = 18;

    // Characters of interest
    localparam logic [7:0] CHR_HASH = 8'h23;
    localparam logic [7:0] CHR_P    = 8'h50;
    localparam logic [7:0] CHR_0    = 8'h30;
    localparam logic [7:0] CHR_1    = 8'h31;
    localparam logic [7:0] CHR_5    = 8'h35;
    localparam logic [7:0] CHR_6    = 8'h36;
    localparam logic [7:0] CHR_9    = 8'h39;
    localparam logic [7:0] CHR_LF   = 8'h0A;

    // Samples per pixel
    localparam logic [1:0] COMP_NONE = 2'd0;
    localparam logic [1:0] COMP_GREY = 2'd1;
    localparam logic [1:0] COMP_RGB  = 2'd3;

    typedef logic signed [REG_W-1:0] t_coord;

    // Header classification travelling with a parsed header
    typedef struct packed {
        t_status    status;
        logic [1:0] components;
    } t_hdr_info;

    // Requested volume of interest
    typedef struct packed {
        t_coord x_min;
        t_coord x_max;
        t_coord y_min;
        t_coord y_max;
        t_coord z_min;
        t_coord z_max;
    } t_voi;

    // Checked region
    typedef struct packed {
        t_coord x_min;
        t_coord x_max;
        t_coord y_min;
        t_coord y_max;
        logic   replaced;
    } t_region;

endpackage

>>> sv/pnm_parse.sv
// Byte-level header scanner: phase machine, number accumulators, header request register.
`include "assert_macros.svh"

module pnm_parse
    import pnm_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_byte,
    input  logic                i_first,
    input  logic                i_last,
    output logic                o_ev_valid,
    input  logic                i_ev_ready,
    output t_hdr_info           o_ev_info,
    output logic [DIM_BITS-1:0] o_ev_w,
    output logic [DIM_BITS-1:0] o_ev_h
);

    // Multiply by ten and add a digit, saturating at the all-ones value
    function automatic logic [DIM_BITS-1:0] f_acc(input logic [DIM_BITS-1:0] acc,
                                                  input logic [7:0] c);
        logic [DIM_BITS+3:0] prod;
        prod = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
             + {{DIM_BITS{1'b0}}, c[3:0]};
        if (|prod[DIM_BITS+3:DIM_BITS])
            return {DIM_BITS{1'b1}};
        return prod[DIM_BITS-1:0];
    endfunction

    t_phase              r_phase, n_phase;
    logic                r_comment, n_comment;
    logic [7:0]          r_type, n_type;
    logic [DIM_BITS-1:0] r_w, n_w;
    logic [DIM_BITS-1:0] r_h, n_h;

    logic                r_ev_valid;
    t_hdr_info           r_ev_info;
    logic [DIM_BITS-1:0] r_ev_w;
    logic [DIM_BITS-1:0] r_ev_h;

    t_phase              eff_phase;
    logic                eff_comment;
    logic                have_char;
    logic                is_digit;
    logic                is_nz_digit;
    logic                emit;
    t_hdr_info           ev_info;
    logic [DIM_BITS-1:0] ev_w;
    logic [DIM_BITS-1:0] ev_h;
    logic                accept;

    assign o_in_ready = !r_ev_valid || i_ev_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_digit    = (i_byte >= CHR_0) && (i_byte <= CHR_9);
    assign is_nz_digit = (i_byte >= CHR_1) && (i_byte <= CHR_9);

    // Hold the parse state; a new file byte restarts it through the next-state logic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEEK_P;
            r_comment <= 1'b0;
            r_type    <= '0;
            r_w       <= '0;
            r_h       <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_comment <= n_comment;
            r_type    <= n_type;
            r_w       <= n_w;
            r_h       <= n_h;
        end
    end

    // Next state and header request for the byte on the input
    always_comb begin
        eff_phase   = i_first ? PH_SEEK_P : r_phase;
        eff_comment = i_first ? 1'b0 : r_comment;
        n_phase     = eff_phase;
        n_comment   = eff_comment;
        n_type      = i_first ? 8'h00 : r_type;
        n_w         = i_first ? '0 : r_w;
        n_h         = i_first ? '0 : r_h;
        have_char   = 1'b0;
        emit        = 1'b0;

        // Strip comments; the closing newline counts as a character
        if (eff_phase != PH_DONE) begin
            if (eff_comment) begin
                if (i_byte == CHR_LF) begin
                    n_comment = 1'b0;
                    have_char = 1'b1;
                end
            end else if (i_byte == CHR_HASH) begin
                n_comment = 1'b1;
            end else begin
                have_char = 1'b1;
            end
        end

        if (have_char) begin
            case (eff_phase)
                PH_SEEK_P: begin
                    if (i_byte == CHR_P)
                        n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    n_type  = i_byte;
                    n_phase = PH_SEEK_W;
                end
                PH_SEEK_W: begin
                    if (is_nz_digit) begin
                        n_w     = f_acc('0, i_byte);
                        n_phase = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    if (is_digit)
                        n_w = f_acc(n_w, i_byte);
                    else
                        n_phase = PH_SEEK_H;
                end
                PH_SEEK_H: begin
                    if (is_nz_digit) begin
                        n_h     = f_acc('0, i_byte);
                        n_phase = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    if (is_digit) begin
                        n_h = f_acc(n_h, i_byte);
                    end else begin
                        emit    = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
                default: begin
                    n_phase = eff_phase;
                end
            endcase
        end

        // Classify the finished header
        ev_w = n_w;
        ev_h = n_h;
        if (n_type == CHR_5) begin
            ev_info.status     = ST_OK;
            ev_info.components = COMP_GREY;
        end else if (n_type == CHR_6) begin
            ev_info.status     = ST_OK;
            ev_info.components = COMP_RGB;
        end else begin
            ev_info.status     = ST_UNKNOWN;
            ev_info.components = COMP_NONE;
        end

        // End of stream closes an open height or reports a truncated header
        if (!emit && i_last && eff_phase != PH_DONE) begin
            emit = 1'b1;
            if (n_phase != PH_HEIGHT) begin
                ev_info.status     = ST_TRUNC;
                ev_info.components = COMP_NONE;
                ev_w               = '0;
                ev_h               = '0;
            end
            n_phase = PH_DONE;
        end
    end

    // Hold the header request until the region stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid <= 1'b0;
        end else if (accept && emit) begin
            r_ev_valid <= 1'b1;
        end else if (i_ev_ready) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_ev_info <= ev_info;
            r_ev_w    <= ev_w;
            r_ev_h    <= ev_h;
        end
    end

    assign o_ev_valid = r_ev_valid;
    assign o_ev_info  = r_ev_info;
    assign o_ev_w     = r_ev_w;
    assign o_ev_h     = r_ev_h;

    `ASSERT_CLK(a_emit_done, i_clk, i_rst_n, $rose(r_ev_valid) |-> r_phase == PH_DONE)
    `ASSERT_CLK(a_trunc_zero, i_clk, i_rst_n, (r_ev_valid && r_ev_info.status == ST_TRUNC) |-> (r_ev_w == '0 && r_ev_h == '0))
    `ASSERT_CLK(a_ok_dims, i_clk, i_rst_n, (r_ev_valid && r_ev_info.status == ST_OK) |-> (r_ev_w != '0 && r_ev_h != '0))

endmodule

>>> sv/pnm_region.sv
// Region check against the parsed extent and the result output register.
`include "assert_macros.svh"

module pnm_region
    import pnm_pkg::*;
#(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ev_valid,
    output logic                o_ev_ready,
    input  t_hdr_info           i_ev_info,
    input  logic [DIM_BITS-1:0] i_ev_w,
    input  logic [DIM_BITS-1:0] i_ev_h,
    input  t_voi                i_voi,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output t_hdr_info           o_out_info,
    output logic [DIM_BITS-1:0] o_out_w,
    output logic [DIM_BITS-1:0] o_out_h,
    output t_region             o_out_region
);

    localparam int CMP_W = ((DIM_BITS > REG_W) ? DIM_BITS : REG_W) + 1;

    logic                    r_out_valid;
    t_hdr_info               r_out_info;
    logic [DIM_BITS-1:0]     r_out_w;
    logic [DIM_BITS-1:0]     r_out_h;
    t_region                 r_out_region;

    logic signed [CMP_W-1:0] w_s, h_s, xmax_s, ymax_s, wm1, hm1;
    logic                    any_req;
    logic                    out_of_range;
    t_region                 n_region;
    logic                    take;

    assign o_ev_ready = !r_out_valid || i_out_ready;
    assign take       = i_ev_valid && o_ev_ready;

    // Compare the request with the image extent
    always_comb begin
        w_s    = $signed({{(CMP_W-DIM_BITS){1'b0}}, i_ev_w});
        h_s    = $signed({{(CMP_W-DIM_BITS){1'b0}}, i_ev_h});
        xmax_s = $signed({{(CMP_W-REG_W){i_voi.x_max[REG_W-1]}}, i_voi.x_max});
        ymax_s = $signed({{(CMP_W-REG_W){i_voi.y_max[REG_W-1]}}, i_voi.y_max});
        wm1    = w_s - $signed(CMP_W'(1));
        hm1    = h_s - $signed(CMP_W'(1));
        any_req = (|i_voi.x_min) || (|i_voi.x_max) || (|i_voi.y_min)
               || (|i_voi.y_max) || (|i_voi.z_min) || (|i_voi.z_max);
        out_of_range = i_voi.x_min[REG_W-1] || (xmax_s >= w_s)
                    || i_voi.y_min[REG_W-1] || (ymax_s >= h_s);

        n_region = '0;
        if (i_ev_info.status == ST_OK) begin
            if (any_req && out_of_range) begin
                n_region.x_min    = '0;
                n_region.x_max    = wm1[REG_W-1:0];
                n_region.y_min    = '0;
                n_region.y_max    = hm1[REG_W-1:0];
                n_region.replaced = 1'b1;
            end else begin
                n_region.x_min    = i_voi.x_min;
                n_region.x_max    = i_voi.x_max;
                n_region.y_min    = i_voi.y_min;
                n_region.y_max    = i_voi.y_max;
                n_region.replaced = 1'b0;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_info   <= i_ev_info;
            r_out_w      <= i_ev_w;
            r_out_h      <= i_ev_h;
            r_out_region <= n_region;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_info   = r_out_info;
    assign o_out_w      = r_out_w;
    assign o_out_h      = r_out_h;
    assign o_out_region = r_out_region;

    `ASSERT_CLK(a_repl_origin, i_clk, i_rst_n, (r_out_valid && r_out_region.replaced) |-> (r_out_region.x_min == '0 && r_out_region.y_min == '0))
    `ASSERT_CLK(a_repl_ok, i_clk, i_rst_n, (r_out_valid && r_out_region.replaced) |-> r_out_info.status == ST_OK)
    `ASSERT_CLK(a_err_empty, i_clk, i_rst_n, (r_out_valid && r_out_info.status != ST_OK) |-> (r_out_region == '0 && r_out_info.components == COMP_NONE))

endmodule

>>> sv/pnm_header_parser_core.sv
// Top level of the binary greymap/pixmap header parser.
//
// Input stream: one file byte per request on s_axis. tdata carries the byte,
// tuser marks the first byte of a file (restarts parsing), tlast the last one.
// Output stream: at most one result per file on m_axis, sent when the height
// field ends, or on the last byte if the header is cut short. tuser carries the
// status; tdata carries the dimensions, samples per pixel and checked region.
// Configuration: write i_cfg_wdata to register i_cfg_addr while i_cfg_we is
// high (x_min, x_max, y_min, y_max, z_min, z_max); write only while idle.
// Throughput: one byte per cycle while s_axis_tready is high.
// A result passes through the header request register, then the output register.
// Reset clears the parser to its search for the magic letter, clears all
// region registers and empties both stages. When the receiver stalls, the
// result waits in the output register; bytes keep flowing until a second
// header waits behind it, then s_axis_tready drops.
module pnm_header_parser_core
    import pnm_pkg::*;
#(
    parameter int DIM_BITS = 16,
    localparam int OUT_BITS = 2 * DIM_BITS + 75,
    localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // data_byte
    input  logic               s_axis_tlast,   // end_of_stream
    input  logic               s_axis_tuser,   // first_byte
    // Output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // image_width, image_height, components, region_x_min, region_x_max,
    // region_y_min, region_y_max, region_replaced, zero fill
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]         m_axis_tuser,   // status
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [REG_W-1:0]   i_cfg_wdata
);

    t_voi                r_voi;
    logic                ev_valid;
    logic                ev_ready;
    t_hdr_info           ev_info;
    logic [DIM_BITS-1:0] ev_w;
    logic [DIM_BITS-1:0] ev_h;
    t_hdr_info           out_info;
    logic [DIM_BITS-1:0] out_w;
    logic [DIM_BITS-1:0] out_h;
    t_region             out_region;

    // Region request registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voi <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_X_MIN: r_voi.x_min <= i_cfg_wdata;
                REG_X_MAX: r_voi.x_max <= i_cfg_wdata;
                REG_Y_MIN: r_voi.y_min <= i_cfg_wdata;
                REG_Y_MAX: r_voi.y_max <= i_cfg_wdata;
                REG_Z_MIN: r_voi.z_min <= i_cfg_wdata;
                REG_Z_MAX: r_voi.z_max <= i_cfg_wdata;
                default:   r_voi       <= r_voi;
            endcase
        end
    end

    pnm_parse #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_first    (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .o_ev_valid (ev_valid),
        .i_ev_ready (ev_ready),
        .o_ev_info  (ev_info),
        .o_ev_w     (ev_w),
        .o_ev_h     (ev_h)
    );

    pnm_region #(
        .DIM_BITS (DIM_BITS)
    ) u_region (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev_valid   (ev_valid),
        .o_ev_ready   (ev_ready),
        .i_ev_info    (ev_info),
        .i_ev_w       (ev_w),
        .i_ev_h       (ev_h),
        .i_voi        (r_voi),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_info   (out_info),
        .o_out_w      (out_w),
        .o_out_h      (out_h),
        .o_out_region (out_region)
    );

    // Pack the result, first field in the low bits
    assign m_axis_tuser = out_info.status;
    assign m_axis_tdata = {{(TDATA_W-OUT_BITS){1'b0}},
                           out_region.replaced,
                           out_region.y_max,
                           out_region.y_min,
                           out_region.x_max,
                           out_region.x_min,
                           out_info.components,
                           out_h,
                           out_w};

endmodule
